@@ src/ile_pkg.sv @@
// ----------------------------------------------------------------------------
// ile_pkg
// shared types and constants of the indexed list engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ile_pkg;

  localparam int CAPACITY_DEF    = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int CMD_W    = 4;
  localparam int ITEM_W   = 32;
  localparam int POS_W    = 7;
  localparam int FIDX_W   = 7;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 7;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND       = 4'd0,
    CMD_INSERT_AT    = 4'd1,
    CMD_ORDERED      = 4'd2,
    CMD_REMOVE_AT    = 4'd3,
    CMD_REMOVE_VALUE = 4'd4,
    CMD_GET          = 4'd5,
    CMD_INDEX_OF     = 4'd6,
    CMD_SWAP         = 4'd7,
    CMD_POP          = 4'd8,
    CMD_CLEAR        = 4'd9
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

endpackage

`default_nettype wire

@@ src/indexed_list_engine.sv @@
// ----------------------------------------------------------------------------
// indexed_list_engine
// bounded list of words in a ram plus a count, one command per beat
// ----------------------------------------------------------------------------
// channel   dir  fields (lowest bit up)
// s_axis    in   tuser: cmd; tdata: item_value, position, other_position
// m_axis    out  tdata: read_value, found_index, status, entry_count
// cfg       in   cfg_wdata_i: order_descending
//
// scans and shifts walk the ram at one entry per cycle through its single
// read port.
// reset clears the count and the order register; the ram needs no clearing.
// a waiting result does not block the next command; a command that
// finishes while a result still waits holds until that beat is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module indexed_list_engine #(
  parameter int CAPACITY    = ile_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = ile_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [0:0]                      cfg_wdata_i,   // order_descending
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // item_value, position, other_position, zero pad
  input  wire logic [ile_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  input  wire logic [ile_pkg::CMD_W-1:0]       s_axis_tuser_i, // cmd
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // read_value, found_index, status, entry_count
  output logic      [ile_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o
);

  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int AW     = $clog2(CAPACITY);
  localparam int VW     = VALUE_WIDTH;
  localparam int POS_W  = ile_pkg::POS_W;
  localparam int ITEM_W = ile_pkg::ITEM_W;
  localparam int FIDX_W = ile_pkg::FIDX_W;
  localparam int CNT_W  = ile_pkg::CNT_W;
  localparam int PW     = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_FETCH,
    S_CAPTURE,
    S_SWAP_RA,
    S_SWAP_RB,
    S_SWAP_WA,
    S_SWAP_WB,
    S_DONE
  } state_e;

  state_e                         state_q, state_d;
  logic [CW-1:0]                  cnt_q, cnt_d;
  logic                           order_q, order_d;
  logic                           act_q, act_d;
  logic                           rv_q, rv_d;
  logic                           m_tvalid_q, m_tvalid_d;

  ile_pkg::cmd_e                  cmd_q, cmd_d;
  logic [VW-1:0]                  val_q, val_d;
  logic [AW-1:0]                  pos_q, pos_d;
  logic [AW-1:0]                  pos2_q, pos2_d;
  logic [CW-1:0]                  iss_q, iss_d;
  logic [AW-1:0]                  src_q, src_d;
  logic [AW-1:0]                  gap_q, gap_d;
  logic [AW-1:0]                  ridx_q, ridx_d;
  logic [AW-1:0]                  wdst_q, wdst_d;
  logic [VW-1:0]                  hold_q, hold_d;
  logic [VW-1:0]                  res_rd_q, res_rd_d;
  logic [FIDX_W-1:0]              res_fidx_q, res_fidx_d;
  ile_pkg::status_e               res_st_q, res_st_d;
  logic [ile_pkg::OUT_DATA_W-1:0] m_tdata_q, m_tdata_d;

  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [VW-1:0]                  ram_wdata;
  logic [AW-1:0]                  ram_raddr;
  logic [VW-1:0]                  ram_rdata;

  ile_pkg::cmd_e                  in_cmd;
  logic [VW-1:0]                  in_val;
  logic [POS_W-1:0]               in_pos;
  logic [POS_W-1:0]               in_pos2;
  logic                           pos_ok;
  logic                           pos2_ok;
  logic                           full;
  logic [CW-1:0]                  cnt_last;
  logic                           hit;

  ile_ram #(
    .WIDTH (VW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_cmd   = ile_pkg::cmd_e'(s_axis_tuser_i);
  assign in_val   = VW'(s_axis_tdata_i[ITEM_W-1:0]);
  assign in_pos   = s_axis_tdata_i[ITEM_W+POS_W-1:ITEM_W];
  assign in_pos2  = s_axis_tdata_i[ITEM_W+2*POS_W-1:ITEM_W+POS_W];
  assign pos_ok   = PW'(in_pos) < PW'(cnt_q);
  assign pos2_ok  = PW'(in_pos2) < PW'(cnt_q);
  assign full     = cnt_q == CW'(CAPACITY);
  assign cnt_last = cnt_q - 1'b1;

  // shared compare unit
  always_comb begin
    if (cmd_q == ile_pkg::CMD_ORDERED) begin
      hit = order_q ? (ram_rdata < val_q) : (ram_rdata > val_q);
    end else begin
      hit = ram_rdata == val_q;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    order_d    = cfg_we_i ? cfg_wdata_i[0] : order_q;
    act_d      = act_q;
    rv_d       = 1'b0;
    m_tvalid_d = m_tvalid_q & ~m_axis_tready_i;
    cmd_d      = cmd_q;
    val_d      = val_q;
    pos_d      = pos_q;
    pos2_d     = pos2_q;
    iss_d      = iss_q;
    src_d      = src_q;
    gap_d      = gap_q;
    ridx_d     = ridx_q;
    wdst_d     = wdst_q;
    hold_d     = hold_q;
    res_rd_d   = res_rd_q;
    res_fidx_d = res_fidx_q;
    res_st_d   = res_st_q;
    m_tdata_d  = m_tdata_q;
    ram_we     = 1'b0;
    ram_waddr  = wdst_q;
    ram_wdata  = ram_rdata;
    ram_raddr  = src_q;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_d      = in_cmd;
          val_d      = in_val;
          pos_d      = AW'(in_pos);
          pos2_d     = AW'(in_pos2);
          res_rd_d   = '0;
          res_fidx_d = '1;
          res_st_d   = ile_pkg::ST_OK;
          iss_d      = '0;
          state_d    = S_DONE;
          case (in_cmd)
            ile_pkg::CMD_APPEND, ile_pkg::CMD_INSERT_AT, ile_pkg::CMD_ORDERED: begin
              if (full) begin
                res_st_d = ile_pkg::ST_FULL;
              end else if (in_cmd == ile_pkg::CMD_APPEND ||
                           (in_cmd == ile_pkg::CMD_INSERT_AT && !pos_ok) ||
                           (in_cmd == ile_pkg::CMD_ORDERED && cnt_q == '0)) begin
                ram_we    = 1'b1;
                ram_waddr = AW'(cnt_q);
                ram_wdata = in_val;
                cnt_d     = cnt_q + 1'b1;
              end else if (in_cmd == ile_pkg::CMD_INSERT_AT) begin
                gap_d   = AW'(in_pos);
                src_d   = AW'(cnt_last);
                act_d   = 1'b1;
                state_d = S_SHIFT_UP;
              end else begin
                state_d = S_SCAN;
              end
            end
            ile_pkg::CMD_REMOVE_AT, ile_pkg::CMD_GET: begin
              if (pos_ok) begin
                src_d   = AW'(in_pos);
                state_d = S_FETCH;
              end else begin
                res_st_d = ile_pkg::ST_INVALID;
              end
            end
            ile_pkg::CMD_REMOVE_VALUE, ile_pkg::CMD_INDEX_OF: begin
              if (cnt_q != '0) begin
                state_d = S_SCAN;
              end else begin
                res_st_d = ile_pkg::ST_INVALID;
              end
            end
            ile_pkg::CMD_SWAP: begin
              if (pos_ok && pos2_ok) begin
                state_d = S_SWAP_RA;
              end else begin
                res_st_d = ile_pkg::ST_INVALID;
              end
            end
            ile_pkg::CMD_POP: begin
              if (cnt_q != '0) begin
                cnt_d   = cnt_last;
                src_d   = AW'(cnt_last);
                state_d = S_FETCH;
              end else begin
                res_st_d = ile_pkg::ST_INVALID;
              end
            end
            ile_pkg::CMD_CLEAR: begin
              cnt_d = '0;
            end
            default: begin
              res_st_d = ile_pkg::ST_INVALID;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (iss_q < cnt_q) begin
          ram_raddr = AW'(iss_q);
          rv_d      = 1'b1;
          ridx_d    = AW'(iss_q);
          iss_d     = iss_q + 1'b1;
        end
        if (rv_q) begin
          if (hit) begin
            rv_d = 1'b0;
            case (cmd_q)
              ile_pkg::CMD_ORDERED: begin
                gap_d   = ridx_q;
                src_d   = AW'(cnt_last);
                act_d   = 1'b1;
                state_d = S_SHIFT_UP;
              end
              ile_pkg::CMD_REMOVE_VALUE: begin
                res_rd_d = val_q;
                src_d    = ridx_q;
                act_d    = 1'b1;
                state_d  = S_SHIFT_DN;
              end
              default: begin
                res_fidx_d = FIDX_W'(ridx_q);
                state_d    = S_DONE;
              end
            endcase
          end else if (CW'(ridx_q) == cnt_last) begin
            rv_d    = 1'b0;
            state_d = S_DONE;
            if (cmd_q == ile_pkg::CMD_ORDERED) begin
              ram_we    = 1'b1;
              ram_waddr = AW'(cnt_q);
              ram_wdata = val_q;
              cnt_d     = cnt_q + 1'b1;
            end else begin
              res_st_d = ile_pkg::ST_INVALID;
            end
          end
        end
      end

      // entries move up one place, highest first
      S_SHIFT_UP: begin
        if (act_q) begin
          ram_raddr = src_q;
          rv_d      = 1'b1;
          wdst_d    = AW'(src_q + 1'b1);
          if (src_q == gap_q) begin
            act_d = 1'b0;
          end else begin
            src_d = src_q - 1'b1;
          end
        end
        if (rv_q) begin
          ram_we = 1'b1;
        end else if (!act_q) begin
          ram_we    = 1'b1;
          ram_waddr = gap_q;
          ram_wdata = val_q;
          cnt_d     = cnt_q + 1'b1;
          state_d   = S_DONE;
        end
      end

      // entries move down one place, lowest first
      S_SHIFT_DN: begin
        if (act_q) begin
          if ((CW'(src_q) + 1'b1) < cnt_q) begin
            ram_raddr = AW'(src_q + 1'b1);
            rv_d      = 1'b1;
            wdst_d    = src_q;
            src_d     = AW'(src_q + 1'b1);
          end else begin
            act_d = 1'b0;
          end
        end
        if (rv_q) begin
          ram_we = 1'b1;
        end else if (!act_q) begin
          cnt_d   = cnt_last;
          state_d = S_DONE;
        end
      end

      S_FETCH: begin
        ram_raddr = src_q;
        state_d   = S_CAPTURE;
      end

      S_CAPTURE: begin
        res_rd_d = ram_rdata;
        if (cmd_q == ile_pkg::CMD_REMOVE_AT) begin
          act_d   = 1'b1;
          state_d = S_SHIFT_DN;
        end else begin
          state_d = S_DONE;
        end
      end

      S_SWAP_RA: begin
        ram_raddr = pos_q;
        state_d   = S_SWAP_RB;
      end

      S_SWAP_RB: begin
        ram_raddr = pos2_q;
        hold_d    = ram_rdata;
        state_d   = S_SWAP_WA;
      end

      S_SWAP_WA: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        state_d   = S_SWAP_WB;
      end

      S_SWAP_WB: begin
        ram_we    = 1'b1;
        ram_waddr = pos2_q;
        ram_wdata = hold_q;
        state_d   = S_DONE;
      end

      S_DONE: begin
        if (!m_tvalid_q || m_axis_tready_i) begin
          m_tvalid_d = 1'b1;
          m_tdata_d  = {CNT_W'(cnt_q), res_st_q, res_fidx_q, ITEM_W'(res_rd_q)};
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      order_q    <= 1'b0;
      act_q      <= 1'b0;
      rv_q       <= 1'b0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      order_q    <= order_d;
      act_q      <= act_d;
      rv_q       <= rv_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    val_q      <= val_d;
    pos_q      <= pos_d;
    pos2_q     <= pos2_d;
    iss_q      <= iss_d;
    src_q      <= src_d;
    gap_q      <= gap_d;
    ridx_q     <= ridx_d;
    wdst_q     <= wdst_d;
    hold_q     <= hold_d;
    res_rd_q   <= res_rd_d;
    res_fidx_q <= res_fidx_d;
    res_st_q   <= res_st_d;
    m_tdata_q  <= m_tdata_d;
  end

  assign s_axis_tready_o = state_q == S_IDLE;
  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |->
      (cnt_q == $past(cnt_q) + 1'b1 || cnt_q == $past(cnt_q) - 1'b1 || cnt_q == '0))
    else $error("entry count moved by more than one");

  a_shift_up_dst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT_UP && rv_q) |-> (wdst_q > gap_q))
    else $error("shift up writes at or below the gap");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_q) |-> $past(state_q == S_DONE))
    else $error("result beat raised outside the done state");
`endif

endmodule

`default_nettype wire

@@ src/ile_ram.sv @@
// ----------------------------------------------------------------------------
// ile_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ile_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ tb/sv/ile_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// ile_tb_pkg
// list tracker for the indexed list engine bench: keeps a shadow copy of the
// list and the order setting, works out the reply of every accepted command
// and compares each reply beat with the oldest one still waiting
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ile_tb_pkg;

  import ile_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 4'd10;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 4'd15;

  localparam int FI_LSB = ITEM_W;
  localparam int ST_LSB = FI_LSB + FIDX_W;
  localparam int CN_LSB = ST_LSB + STATUS_W;

  localparam int unsigned PRINT_CAP = 40;

  typedef struct {
    logic [ITEM_W-1:0]   read_value;
    logic [FIDX_W-1:0]   found_index;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    entry_count;
  } reply_t;

  class list_tracker;
    logic [ITEM_W-1:0] shadow_list[$];
    bit                descending;
    reply_t            pending_replies[$];
    int unsigned       mismatches;

    function new();
      descending = 1'b0;
      mismatches = 0;
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= PRINT_CAP) begin
        $display("[%0t] mismatch: %s", $realtime, what);
      end
    endtask

    function int find_entry(logic [ITEM_W-1:0] v);
      foreach (shadow_list[i]) begin
        if (shadow_list[i] == v) return i;
      end
      return -1;
    endfunction

    function void note_command(logic [CMD_W-1:0] op, logic [ITEM_W-1:0] v,
                               logic [POS_W-1:0] p, logic [POS_W-1:0] p2);
      reply_t            r;
      int                n;
      int                k;
      logic [ITEM_W-1:0] t;
      r.read_value  = '0;
      r.found_index = '1;
      r.status      = ST_OK;
      n = shadow_list.size();
      case (op)
        CMD_APPEND, CMD_INSERT_AT, CMD_ORDERED: begin
          if (n >= CAPACITY_DEF) begin
            r.status = ST_FULL;
          end else begin
            k = n;
            if (op == CMD_INSERT_AT && p < n) begin
              k = p;
            end else if (op == CMD_ORDERED) begin
              k = 0;
              while (k < n && !(descending ? shadow_list[k] < v : shadow_list[k] > v)) k++;
            end
            shadow_list.insert(k, v);
          end
        end
        CMD_REMOVE_AT: begin
          if (p < n) begin
            r.read_value = shadow_list[p];
            shadow_list.delete(p);
          end else begin
            r.status = ST_INVALID;
          end
        end
        CMD_REMOVE_VALUE: begin
          k = find_entry(v);
          if (k >= 0) begin
            r.read_value = v;
            shadow_list.delete(k);
          end else begin
            r.status = ST_INVALID;
          end
        end
        CMD_GET: begin
          if (p < n) r.read_value = shadow_list[p];
          else r.status = ST_INVALID;
        end
        CMD_INDEX_OF: begin
          k = find_entry(v);
          if (k >= 0) r.found_index = FIDX_W'(k);
          else r.status = ST_INVALID;
        end
        CMD_SWAP: begin
          if (p < n && p2 < n) begin
            t = shadow_list[p];
            shadow_list[p] = shadow_list[p2];
            shadow_list[p2] = t;
          end else begin
            r.status = ST_INVALID;
          end
        end
        CMD_POP: begin
          if (n > 0) begin
            r.read_value = shadow_list[n-1];
            shadow_list.delete(n-1);
          end else begin
            r.status = ST_INVALID;
          end
        end
        CMD_CLEAR: begin
          shadow_list.delete();
        end
        default: begin
          r.status = ST_INVALID;
        end
      endcase
      r.entry_count = CNT_W'(shadow_list.size());
      pending_replies.push_back(r);
    endfunction

    task check_reply(logic [OUT_DATA_W-1:0] d);
      reply_t e;
      if (pending_replies.size() == 0) begin
        report($sformatf("reply beat %h with nothing outstanding", d));
        return;
      end
      e = pending_replies.pop_front();
      if (d[0 +: ITEM_W] !== e.read_value)
        report($sformatf("read_value %h, want %h", d[0 +: ITEM_W], e.read_value));
      if (d[FI_LSB +: FIDX_W] !== e.found_index)
        report($sformatf("found_index %h, want %h", d[FI_LSB +: FIDX_W], e.found_index));
      if (d[ST_LSB +: STATUS_W] !== e.status)
        report($sformatf("status %0d, want %0d", d[ST_LSB +: STATUS_W], e.status));
      if (d[CN_LSB +: CNT_W] !== e.entry_count)
        report($sformatf("entry_count %0d, want %0d", d[CN_LSB +: CNT_W], e.entry_count));
    endtask
  endclass

endpackage

@@ tb/sv/tb_indexed_list_engine.sv @@
// ----------------------------------------------------------------------------
// tb_indexed_list_engine
// stream bench for the indexed list engine: a directed sweep of the corner
// cases, then random command mixes that grow, churn and drain the list under
// both sort orders, with random gaps on the command side and random stalls on
// the reply side
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_indexed_list_engine;

  import ile_pkg::*;
  import ile_tb_pkg::*;

  localparam int          CLK_PERIOD  = 8;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned PHASE_ITEMS = 240;

  typedef enum int {MIX_GROW, MIX_CHURN, MIX_DRAIN} mix_e;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [0:0] cfg_wdata;
  logic s_valid;
  logic s_ready;
  logic [IN_DATA_W-1:0] s_data;
  logic [CMD_W-1:0] s_user;
  logic m_valid;
  logic m_ready;
  logic [OUT_DATA_W-1:0] m_data;

  bit          calm;
  list_tracker book;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  indexed_list_engine DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [CMD_W-1:0] pick_op(mix_e mix);
    int unsigned wt [16];
    int unsigned sum;
    int unsigned r;
    case (mix)
      MIX_GROW:  wt = '{14, 16, 20, 4, 4, 8, 8, 6, 3, 0, 1, 1, 1, 1, 1, 1};
      MIX_CHURN: wt = '{8, 8, 10, 10, 10, 10, 10, 10, 6, 1, 1, 1, 1, 1, 1, 1};
      default:   wt = '{3, 3, 4, 18, 18, 8, 8, 6, 14, 1, 1, 1, 1, 1, 1, 1};
    endcase
    sum = 0;
    foreach (wt[i]) sum += wt[i];
    r = $urandom_range(0, sum - 1);
    foreach (wt[i]) begin
      if (r < wt[i]) return CMD_W'(i);
      r -= wt[i];
    end
    return CMD_APPEND;
  endfunction

  // mostly values already held or small ones, so searches and ties hit
  function automatic logic [ITEM_W-1:0] pick_value();
    int unsigned n;
    int unsigned r;
    n = book.shadow_list.size();
    r = $urandom_range(0, 9);
    if (n > 0 && r < 4) return book.shadow_list[$urandom_range(0, n - 1)];
    if (r < 7) return ITEM_W'($urandom_range(0, 15));
    if (r == 7) begin
      case ($urandom_range(0, 2))
        0:       return '0;
        1:       return '1;
        default: return {1'b1, {(ITEM_W-1){1'b0}}};
      endcase
    end
    return $urandom();
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    int unsigned n;
    int unsigned r;
    n = book.shadow_list.size();
    r = $urandom_range(0, 9);
    if (r < 6) return POS_W'($urandom_range(0, (n > 0) ? n - 1 : 0));
    if (r < 8) return POS_W'(n);
    return POS_W'($urandom_range(0, (1 << POS_W) - 1));
  endfunction

  task automatic idle_input();
    @(negedge clk_i) s_valid <= 1'b0;
  endtask

  task automatic send_command(logic [CMD_W-1:0] op, logic [ITEM_W-1:0] v,
                              logic [POS_W-1:0] p, logic [POS_W-1:0] p2);
    int unsigned          gap;
    logic [IN_DATA_W-1:0] beat;
    gap = pick_gap();
    beat = '0;
    beat[0 +: ITEM_W] = v;
    beat[ITEM_W +: POS_W] = p;
    beat[ITEM_W + POS_W +: POS_W] = p2;
    if (gap > 0) begin
      @(negedge clk_i) s_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= beat;
    do @(posedge clk_i); while (!s_ready);
    book.note_command(op, v, p, p2);
  endtask

  task automatic settle();
    idle_input();
    while (book.pending_replies.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_order(bit descending);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= descending;
    @(negedge clk_i) cfg_we <= 1'b0;
    book.descending = descending;
  endtask

  task automatic run_mix(mix_e mix, int unsigned items);
    logic [CMD_W-1:0]  op;
    logic [ITEM_W-1:0] v;
    logic [POS_W-1:0]  p;
    logic [POS_W-1:0]  p2;
    repeat (items) begin
      op = pick_op(mix);
      v  = pick_value();
      p  = pick_position();
      p2 = pick_position();
      send_command(op, v, p, p2);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) book.check_reply(m_data);
  end

  initial begin : reply_sink
    int unsigned n;
    m_ready = 1'b0;
    @(negedge clk_i);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        m_ready <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      m_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL indexed_list_engine");
    $finish;
  end

  initial begin
    book      = new();
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    s_valid   = 1'b0;
    s_data    = '0;
    s_user    = CMD_APPEND;
    calm      = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    write_order(1'b0);

    // empty list corners
    send_command(CMD_POP, '0, '0, '0);
    send_command(CMD_GET, '0, '0, '0);
    send_command(CMD_REMOVE_AT, '0, '0, '0);
    send_command(CMD_SWAP, '0, '0, '0);
    send_command(CMD_INDEX_OF, '0, '0, '0);
    send_command(CMD_REMOVE_VALUE, '0, '0, '0);
    // fill, insert past the end appends
    send_command(CMD_APPEND, '0, '0, '0);
    send_command(CMD_APPEND, '1, '1, '1);
    send_command(CMD_INSERT_AT, 32'h8000_0001, '1, '0);
    send_command(CMD_INSERT_AT, 32'h1234_5678, '0, '1);
    send_command(CMD_ORDERED, 32'h0000_0005, '0, '0);
    send_command(CMD_GET, '0, 7'd2, '0);
    send_command(CMD_INDEX_OF, '1, '0, '0);
    send_command(CMD_INDEX_OF, 32'hDEAD_BEEF, '0, '0);
    send_command(CMD_SWAP, '0, 7'd0, 7'd4);
    send_command(CMD_SWAP, '0, 7'd1, '1);
    send_command(CMD_REMOVE_VALUE, '0, '0, '0);
    send_command(CMD_REMOVE_AT, '0, 7'd3, '0);
    send_command(CMD_REMOVE_AT, '0, '1, '0);
    send_command(CMD_GET, '0, '1, '0);
    send_command(CMD_SPARE_LO, '1, '1, '1);
    send_command(CMD_SPARE_HI, '0, '0, '0);
    send_command(CMD_POP, '0, '0, '0);
    send_command(CMD_CLEAR, '0, '0, '0);
    send_command(CMD_POP, '0, '0, '0);

    for (int ph = 0; ph < 8; ph++) begin
      settle();
      write_order(ph % 2 == 1);
      calm = (ph % 4 == 3);
      run_mix(mix_e'(ph % 3), PHASE_ITEMS);
    end
    settle();
    repeat (160) @(posedge clk_i);

    if (book.mismatches == 0) begin
      $display("PASS indexed_list_engine");
    end else begin
      $display("FAIL indexed_list_engine");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/ile_pkg.sv
src/ile_ram.sv
src/indexed_list_engine.sv
tb/sv/ile_tb_pkg.sv
tb/sv/tb_indexed_list_engine.sv
